// ----- design/oct_pkg.sv -----
// Package: command and status codes and field widths for the occurrence count table.
package oct_pkg;

  localparam int VALUE_BITS   = 32;
  localparam int INDEX_BITS   = 4;
  localparam int CMD_BITS     = 2;
  localparam int STATUS_BITS  = 3;
  localparam int OUT_CNT_BITS = 16;
  localparam int USED_BITS    = 5;

  localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_ADD   = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_COUNTED  = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_NEW      = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_READ_OK  = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_READ_BAD = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_CLEARED  = 3'd5;

endpackage

// ----- design/occurrence_count_table_top.sv -----
// Occurrence count table: holds up to ENTRIES distinct values with saturating counts, in
// order of first appearance, and answers clear, add and read commands one item each.
// The block takes one item per cycle unless the output is held back: an item is captured
// in an input register, then the stage, when free to advance, compares it against every held entry at
// once, updates the table and loads the result register. The parallel compare over all
// entries sets the clock-to-clock path. Commands act on the table in arrival order, so
// an add is seen by the item right behind it. Reset empties the table; no clearing pass.
module occurrence_count_table_top #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command [1:0], value [33:2], index [37:34], zero [39:38]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status [2:0], entry_value [34:3], entry_count [50:35], used_entries [55:51]
  output logic [55:0] m_axis_tdata
);

  localparam int IDXW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FILLW = $clog2(ENTRIES + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // table storage
  logic signed [oct_pkg::VALUE_BITS-1:0] values [ENTRIES];
  logic        [COUNT_BITS-1:0]          counts [ENTRIES];
  logic        [FILLW-1:0]               fill;
  logic        [FILLW-1:0]               fill_next;

  // input register
  logic                                  s1_valid;
  logic        [oct_pkg::CMD_BITS-1:0]   s1_command;
  logic signed [oct_pkg::VALUE_BITS-1:0] s1_value;
  logic        [oct_pkg::INDEX_BITS-1:0] s1_index;
  logic                                  s1_adv;

  // result register
  logic                                   out_valid;
  logic        [oct_pkg::STATUS_BITS-1:0] out_status;
  logic signed [oct_pkg::VALUE_BITS-1:0]  out_value;
  logic        [oct_pkg::OUT_CNT_BITS-1:0] out_count;
  logic        [oct_pkg::USED_BITS-1:0]   out_used;

  // per-item logic
  logic        [ENTRIES-1:0]              match;
  logic                                   found;
  logic        [COUNT_BITS-1:0]           hit_count;
  logic        [COUNT_BITS-1:0]           hit_sat;
  logic                                   has_room;
  logic                                   rd_ok;
  logic        [IDXW-1:0]                 rd_addr;
  logic        [IDXW-1:0]                 wr_addr;
  logic                                   do_append;
  logic                                   do_count;
  logic        [oct_pkg::STATUS_BITS-1:0] status_next;
  logic signed [oct_pkg::VALUE_BITS-1:0]  value_next;
  logic        [COUNT_BITS-1:0]           count_next;

  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;

  always_comb begin
    match     = '0;
    hit_count = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = (FILLW'(i) < fill) && (values[i] == s1_value);
      hit_count = hit_count | (counts[i] & {COUNT_BITS{match[i]}});
    end
  end

  assign found    = |match;
  assign hit_sat  = (hit_count == COUNT_MAX) ? hit_count : hit_count + COUNT_BITS'(1);
  assign has_room = fill < FILLW'(ENTRIES);
  assign rd_ok    = 32'(s1_index) < 32'(fill);
  assign rd_addr  = IDXW'(s1_index);
  assign wr_addr  = IDXW'(fill);

  always_comb begin
    status_next = oct_pkg::ST_READ_BAD;
    value_next  = '0;
    count_next  = '0;
    fill_next   = fill;
    do_append   = 1'b0;
    do_count    = 1'b0;
    case (s1_command)
      oct_pkg::CMD_CLEAR: begin
        status_next = oct_pkg::ST_CLEARED;
        fill_next   = '0;
      end
      oct_pkg::CMD_ADD: begin
        value_next = s1_value;
        if (found) begin
          status_next = oct_pkg::ST_COUNTED;
          count_next  = hit_sat;
          do_count    = 1'b1;
        end else if (has_room) begin
          status_next = oct_pkg::ST_NEW;
          count_next  = COUNT_BITS'(1);
          fill_next   = fill + FILLW'(1);
          do_append   = 1'b1;
        end else begin
          status_next = oct_pkg::ST_FULL;
        end
      end
      default: begin
        // both read codes: the high bit selects read
        if (rd_ok) begin
          status_next = oct_pkg::ST_READ_OK;
          value_next  = values[rd_addr];
          count_next  = counts[rd_addr];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_command <= s_axis_tdata[1:0];
      s1_value   <= s_axis_tdata[33:2];
      s1_index   <= s_axis_tdata[37:34];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (s1_adv) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && do_append) begin
      values[wr_addr] <= s1_value;
      counts[wr_addr] <= COUNT_BITS'(1);
    end
    if (s1_adv && do_count) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (match[i]) begin
          counts[i] <= hit_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status <= status_next;
      out_value  <= value_next;
      out_count  <= oct_pkg::OUT_CNT_BITS'(count_next);
      out_used   <= oct_pkg::USED_BITS'(fill_next);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_used, out_count, out_value, out_status};

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILLW'(ENTRIES))
    else $error("fill level beyond table size");

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  a_new_grows_fill: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && status_next == oct_pkg::ST_NEW) |=> (fill == $past(fill) + FILLW'(1)))
    else $error("new entry did not grow the table");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_command == oct_pkg::CMD_CLEAR) |=> (fill == '0 && out_used == '0))
    else $error("clear left entries in the table");
`endif

endmodule
